FILE: design/lcsl_pkg.sv
// Package for the longest common substring length block.
// Holds transaction structs, the sequencer state type, cell control and default sizes.
// No dependencies.
package lcsl_pkg;

	localparam int MAX_FIRST_DEF   = 64;
	localparam int SYMBOL_BITS_DEF = 8;
	localparam int SYMBOL_W        = 8;
	localparam int LEN_OUT_W       = 7;
	localparam int LEN_OUT_MAX     = 127;

	typedef struct packed {
		logic                kind;
		logic [SYMBOL_W-1:0] symbol;
		logic                symbol_present;
		logic                is_last;
	} lcsl_in_t;

	typedef struct packed {
		logic [LEN_OUT_W-1:0] longest_length;
		logic                 overflowed;
	} lcsl_out_t;

	typedef struct packed {
		logic clear;
		logic upd;
	} lcsl_cell_ctl_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_DRAIN,
		ST_EMIT
	} lcsl_state_t;

endpackage

FILE: design/lcsl_cell.sv
// One cell of the run-length chain: one first-string symbol, its run length,
// its own best run and one stage of the running-maximum chain. Depends on lcsl_pkg.
module lcsl_cell #(
	parameter int RUN_W       = 7,
	parameter int SYMBOL_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lcsl_pkg::lcsl_cell_ctl_t ctl,
	input  logic                   load,
	input  logic                   active,
	input  logic [SYMBOL_BITS-1:0] sym,
	input  logic [RUN_W-1:0]       run_in,
	input  logic [RUN_W-1:0]       agg_in,
	output logic [RUN_W-1:0]       run_out,
	output logic [RUN_W-1:0]       agg_out
);
	import lcsl_pkg::*;

	logic [SYMBOL_BITS-1:0] sym_q;
	logic [RUN_W-1:0]       run_q;
	logic [RUN_W-1:0]       best_q;
	logic [RUN_W-1:0]       agg_q;
	logic [RUN_W-1:0]       run_nxt;

	// Extend the neighbor's run on a match, else restart at zero.
	assign run_nxt = (sym_q == sym) ? RUN_W'(run_in + RUN_W'(1)) : '0;

	always_ff @(posedge clk) begin
		if (load) begin
			sym_q <= sym;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= '0;
			best_q <= '0;
			agg_q  <= '0;
		end else if (ctl.clear) begin
			run_q  <= '0;
			best_q <= '0;
			agg_q  <= '0;
		end else begin
			if (ctl.upd && active) begin
				run_q <= run_nxt;
				if (run_nxt > best_q) begin
					best_q <= run_nxt;
				end
			end
			agg_q <= (best_q > agg_in) ? best_q : agg_in;
		end
	end

	assign run_out = run_q;
	assign agg_out = agg_q;

endmodule

FILE: design/longest_common_substring_length.sv
// Top level of the longest common substring length block: sequencer, string
// length count, overflow flag, result register and the row of lcsl_cell.
// Depends on lcsl_pkg and lcsl_cell.
//
//  channel | signals                        | direction | transaction
//  --------+--------------------------------+-----------+--------------------------------
//  in      | in_valid, in_ready, in_data    | into      | one symbol or end mark (lcsl_in_t)
//  out     | out_valid, out_ready, out_data | out of    | one result per pair (lcsl_out_t)
//
// Every input transaction is taken as soon as it is valid, except the last item
// of the second string: after it the running maximum walks down the chain of
// MAX_FIRST cells in state DRAIN, then state EMIT hands it to the result register,
// so in_ready stays low through DRAIN and EMIT, and EMIT waits longer if the result
// register is still full. Reset clears all control and run-length state at once;
// no clearing pass. A stalled result waits in the output register while new
// transactions of the next pair are taken.
module longest_common_substring_length #(
	parameter int MAX_FIRST   = lcsl_pkg::MAX_FIRST_DEF,
	parameter int SYMBOL_BITS = lcsl_pkg::SYMBOL_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lcsl_pkg::lcsl_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lcsl_pkg::lcsl_out_t out_data
);
	import lcsl_pkg::*;

	// Run lengths reach MAX_FIRST; the first-string count reaches MAX_FIRST too.
	localparam int RUN_W = $clog2(MAX_FIRST + 1);
	localparam int LEN_W = $clog2(MAX_FIRST + 1);
	localparam int CNT_W = (MAX_FIRST > 1) ? $clog2(MAX_FIRST) : 1;

	lcsl_state_t state_q, state_nxt;

	logic [LEN_W-1:0]       first_len_q;
	logic                   overflow_q;
	logic [CNT_W-1:0]       drain_cnt_q;
	logic                   out_valid_q;
	lcsl_out_t              out_data_q;

	logic                   in_fire;
	logic                   emit;
	logic                   first_sym;
	logic                   second_sym;
	logic                   pair_end;
	logic                   store_full;
	lcsl_cell_ctl_t         cell_ctl;
	logic [31:0]            sym32;
	logic [SYMBOL_BITS-1:0] sym_in;
	logic [31:0]            best32;
	logic [LEN_OUT_W-1:0]   best_sat;

	logic [MAX_FIRST-1:0]   load_vec;
	logic [MAX_FIRST-1:0]   active_vec;
	logic [RUN_W-1:0]       run_w [MAX_FIRST];
	logic [RUN_W-1:0]       agg_w [MAX_FIRST];

	assign in_fire    = in_valid && in_ready;
	assign first_sym  = in_fire && !in_data.kind && in_data.symbol_present;
	assign second_sym = in_fire && in_data.kind && in_data.symbol_present;
	assign pair_end   = in_fire && in_data.kind && in_data.is_last;
	assign store_full = (first_len_q == LEN_W'(MAX_FIRST));

	// Only the low SYMBOL_BITS bits of a symbol take part in comparisons.
	assign sym32  = 32'(in_data.symbol);
	assign sym_in = sym32[SYMBOL_BITS-1:0];

	// Sequencer: take items in RUN, let the maximum settle in DRAIN, hand the
	// result to the output register and clear the pair in EMIT.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		emit      = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				in_ready = 1'b1;
				if (in_valid && in_data.kind && in_data.is_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_cnt_q == CNT_W'(MAX_FIRST - 1)) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// Hold until the output register is free.
				if (!out_valid_q || out_ready) begin
					emit      = 1'b1;
					state_nxt = ST_RUN;
				end
			end
			default: begin
				state_nxt = ST_RUN;
			end
		endcase
	end

	// Count drain cycles; restart at each pair end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_cnt_q <= '0;
		end else if (pair_end) begin
			drain_cnt_q <= '0;
		end else if (state_q == ST_DRAIN) begin
			drain_cnt_q <= CNT_W'(drain_cnt_q + CNT_W'(1));
		end
	end

	// First-string length and overflow flag; drop symbols beyond capacity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_len_q <= '0;
			overflow_q  <= 1'b0;
		end else if (emit) begin
			first_len_q <= '0;
			overflow_q  <= 1'b0;
		end else if (first_sym) begin
			if (store_full) begin
				overflow_q <= 1'b1;
			end else begin
				first_len_q <= LEN_W'(first_len_q + LEN_W'(1));
			end
		end
	end

	assign cell_ctl.clear = emit;
	assign cell_ctl.upd   = second_sym;

	// Row of cells: each takes its lower neighbor's run and running maximum.
	for (genvar k = 0; k < MAX_FIRST; k++) begin : g_cell
		logic [RUN_W-1:0] run_below;
		logic [RUN_W-1:0] agg_below;

		assign load_vec[k]   = first_sym && (first_len_q == LEN_W'(k));
		assign active_vec[k] = (LEN_W'(k) < first_len_q);

		if (k == 0) begin : g_head
			assign run_below = '0;
			assign agg_below = '0;
		end else begin : g_body
			assign run_below = run_w[k-1];
			assign agg_below = agg_w[k-1];
		end

		lcsl_cell #(
			.RUN_W       (RUN_W),
			.SYMBOL_BITS (SYMBOL_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl),
			.load    (load_vec[k]),
			.active  (active_vec[k]),
			.sym     (sym_in),
			.run_in  (run_below),
			.agg_in  (agg_below),
			.run_out (run_w[k]),
			.agg_out (agg_w[k])
		);
	end

	// Saturate the maximum at the output field's range.
	assign best32   = 32'(agg_w[MAX_FIRST-1]);
	assign best_sat = (best32 > 32'(LEN_OUT_MAX)) ? LEN_OUT_W'(LEN_OUT_MAX)
	                                              : best32[LEN_OUT_W-1:0];

	// Output register: lets the next pair start while the result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q.longest_length <= best_sat;
			out_data_q.overflowed     <= overflow_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		first_len_q <= LEN_W'(MAX_FIRST))
		else $error("first-string length beyond capacity");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> store_full)
		else $error("overflow flag set while store not full");

	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		pair_end |=> (state_q == ST_DRAIN) && !in_ready)
		else $error("pair end did not start the drain");

	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q && (first_len_q == '0) && !overflow_q)
		else $error("result not registered or pair not cleared");

endmodule
